### rtl/pacomp_pkg.sv
// package: item types, codes, fixed-point constants and lookup tables for the layer compositor
package pacomp_pkg;

	// default sizes handed to the top level
	localparam int DEF_MAX_PIXELS  = 65536;
	localparam int DEF_COLOUR_BITS = 20;

	// depth of the result queue and the number of readouts that may be outstanding
	localparam int OUT_DEPTH = 16;

	// one in q.16
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// operation codes
	localparam logic [1:0] OP_FRESH = 2'd0;
	localparam logic [1:0] OP_BLEND = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// blend modes
	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_ALPHA   = 2'd1;
	localparam logic [1:0] MODE_MUL_RED = 2'd2;
	localparam logic [1:0] MODE_PREMUL  = 2'd3;

	// input item
	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] pixel_index;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [7:0]  alpha_in;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
	} out_item_t;

	// 256 entries of q.16
	typedef logic [255:0][16:0] q16_tab_t;

	// srgb byte to linear q.16: linear segment, then the 2.4 power via a fifth-root search
	function automatic logic [16:0] lin_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] y;
		logic [63:0] cand;
		logic [63:0] p;
		logic [63:0] r;
		x = '0;
		x2 = '0;
		y = '0;
		if (k <= 32'd10) begin
			r = (64'd6553600 * 64'(k) + 64'd164730) / 64'd329460;
		end else begin
			x = (64'(1000 * k + 14025) << 30) / 64'd269025;
			x2 = (x * x) >> 30;
			for (int b = 30; b >= 0; b--) begin
				cand = y | (64'd1 << b);
				p = cand;
				for (int i = 0; i < 4; i++) begin
					p = (p * cand) >> 30;
				end
				if (cand <= (64'd1 << 30) && p <= x2) begin
					y = cand;
				end
			end
			r = (x2 * y + (64'd1 << 43)) >> 44;
		end
		return r[16:0];
	endfunction

	function automatic q16_tab_t lin_table_build();
		q16_tab_t t;
		for (int k = 0; k < 256; k++) begin
			t[k] = lin_entry(k);
		end
		return t;
	endfunction

	// alpha byte to q.16, rounded so that 255 gives one
	function automatic q16_tab_t alpha_table_build();
		q16_tab_t t;
		logic [31:0] v;
		for (int k = 0; k < 256; k++) begin
			v = (32'(k) * 32'd65536 + 32'd127) / 32'd255;
			t[k] = v[16:0];
		end
		return t;
	endfunction

	localparam q16_tab_t LIN_TAB   = lin_table_build();
	localparam q16_tab_t ALPHA_TAB = alpha_table_build();

endpackage

### rtl/premul_alpha_layer_compositor_top.sv
// top level: premultiplied-alpha compositor over a linear frame store
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_we               cfg_wdata (blend mode)
//  in        in         in_valid / in_stall  in_data   (pacomp_pkg::in_item_t)
//  out       out        out_valid / out_stall out_data (pacomp_pkg::out_item_t)
//
// one item is taken every cycle unless in_stall is high; blends write the store from stage 4,
// and a readout result passes stages 1 to 7 into the result queue before it shows on out.
// back-to-back blends on one pixel are forwarded from the write stage and the stage after it.
// results wait in a 16-entry queue; in_stall rises only while 16 readouts are outstanding,
// so the pipeline itself never halts.
// reset clears the blend mode, valid bits and queue; the store is left as it is.
module premul_alpha_layer_compositor_top #(
	parameter int MAX_PIXELS  = pacomp_pkg::DEF_MAX_PIXELS,
	parameter int COLOUR_BITS = pacomp_pkg::DEF_COLOUR_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pacomp_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pacomp_pkg::out_item_t out_data
);

	localparam int CB     = COLOUR_BITS;
	localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int WORD_W = 3 * CB + 17;
	localparam int OCNT_W = $clog2(pacomp_pkg::OUT_DEPTH + 1);
	localparam int PTR_W  = $clog2(pacomp_pkg::OUT_DEPTH);

	// one step of the largest-k search over the linear table
	function automatic logic [7:0] srch(input logic [7:0] n, input logic [CB-1:0] v,
		input logic [7:0] b);
		logic [7:0] c;
		c = n | b;
		return (CB'(pacomp_pkg::LIN_TAB[c]) <= v) ? c : n;
	endfunction

	logic [1:0] mode_q;
	logic [OCNT_W-1:0] resv_q;
	logic in_acc;
	logic out_acc;

	// stage 1
	logic vld_s1;
	logic inr_s1;
	pacomp_pkg::in_item_t itm_s1;

	// stage 2
	logic vld_s2;
	logic inr_s2;
	logic [1:0] op_s2;
	logic [15:0] idx_s2;
	logic [2:0][16:0] lin_s2;
	logic [16:0] alf_s2;

	// stage 3
	logic wr_s3;
	logic rdo_s3;
	logic fresh_s3;
	logic [15:0] idx_s3;
	logic [2:0][16:0] src_s3;
	logic [16:0] inv_s3;

	// stage 4
	logic wr_s4;
	logic [15:0] idx_s4;
	logic [2:0][CB:0] mul_s4;
	logic [16:0] tn_s4;
	logic [2:0][16:0] src_s4;
	logic rdo_s4;
	logic [2:0][CB-1:0] rcol_s4;
	logic [16:0] rt_s4;

	// stage 5 and later
	logic wr_s5;
	logic [15:0] idx_s5;
	logic [WORD_W-1:0] wdat_s5;
	logic rdo_s5;
	logic rdo_s6;
	logic rdo_s7;
	logic [2:0][CB-1:0] rcol_s5;
	logic [2:0][CB-1:0] rcol_s6;
	logic [2:0][CB-1:0] rcol_s7;
	logic [2:0][7:0] rn_s5;
	logic [2:0][7:0] rn_s6;
	logic [2:0][7:0] rn_s7;
	logic [7:0] ra_s5;
	logic [7:0] ra_s6;
	logic [7:0] ra_s7;

	// store ports
	logic re;
	logic [ADDR_W-1:0] raddr;
	logic [WORD_W-1:0] rdata;
	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [WORD_W-1:0] wdata;

	// combinational
	logic [2:0][33:0] prod2;
	logic [2:0][16:0] src2;
	logic [16:0] inv2;
	logic [WORD_W-1:0] dstw;
	logic [2:0][CB-1:0] dst3;
	logic [16:0] t3;
	logic [2:0][CB+16:0] prod3;
	logic [33:0] tprod3;
	logic [2:0][CB+1:0] sum4;
	logic [2:0][CB-1:0] col4;
	logic [2:0][7:0] n4;
	logic [16:0] tc4;
	logic [16:0] cov4;
	logic [24:0] am4;
	logic [2:0][7:0] n5;
	logic [2:0][7:0] n6;
	logic [2:0][7:0] n7;

	// result queue
	pacomp_pkg::out_item_t fifo_q [pacomp_pkg::OUT_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [OCNT_W-1:0] ocnt_q;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (resv_q == OCNT_W'(pacomp_pkg::OUT_DEPTH));

	// blend mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pacomp_pkg::MODE_ADD;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// readout slots held from acceptance until the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= '0;
		end else begin
			if (in_acc && in_data.operation == pacomp_pkg::OP_READ && !out_acc) begin
				resv_q <= resv_q + 1'b1;
			end else if (out_acc &&
				!(in_acc && in_data.operation == pacomp_pkg::OP_READ)) begin
				resv_q <= resv_q - 1'b1;
			end
		end
	end

	// valid bits down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			wr_s3 <= 1'b0;
			rdo_s3 <= 1'b0;
			wr_s4 <= 1'b0;
			rdo_s4 <= 1'b0;
			wr_s5 <= 1'b0;
			rdo_s5 <= 1'b0;
			rdo_s6 <= 1'b0;
			rdo_s7 <= 1'b0;
		end else begin
			vld_s1 <= in_acc && in_data.operation != pacomp_pkg::OP_NONE;
			vld_s2 <= vld_s1;
			wr_s3 <= vld_s2 && inr_s2 &&
				(op_s2 == pacomp_pkg::OP_FRESH || op_s2 == pacomp_pkg::OP_BLEND);
			rdo_s3 <= vld_s2 && op_s2 == pacomp_pkg::OP_READ;
			wr_s4 <= wr_s3;
			rdo_s4 <= rdo_s3;
			wr_s5 <= wr_s4;
			rdo_s5 <= rdo_s4;
			rdo_s6 <= rdo_s5;
			rdo_s7 <= rdo_s6;
		end
	end

	// stage 1: register the item and its range check
	always_ff @(posedge clk) begin
		itm_s1 <= in_data;
		inr_s1 <= 32'(in_data.pixel_index) < MAX_PIXELS;
	end

	// stage 2: linearize colour and alpha
	always_ff @(posedge clk) begin
		op_s2 <= itm_s1.operation;
		idx_s2 <= itm_s1.pixel_index;
		inr_s2 <= inr_s1;
		lin_s2[0] <= pacomp_pkg::LIN_TAB[itm_s1.red_in];
		lin_s2[1] <= pacomp_pkg::LIN_TAB[itm_s1.green_in];
		lin_s2[2] <= pacomp_pkg::LIN_TAB[itm_s1.blue_in];
		alf_s2 <= pacomp_pkg::ALPHA_TAB[itm_s1.alpha_in];
	end

	// store read for blends onto a stored pixel and readouts
	assign re = vld_s2 && inr_s2 && op_s2 != pacomp_pkg::OP_FRESH;
	assign raddr = ADDR_W'(idx_s2);

	// stage 2 logic: per-mode source and destination factor (one minus alpha in two modes)
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod2[ch] = 34'(lin_s2[ch]) * 34'(alf_s2);
		end
		unique case (mode_q)
			pacomp_pkg::MODE_ADD: begin
				inv2 = pacomp_pkg::ONE_Q16;
				src2 = lin_s2;
			end
			pacomp_pkg::MODE_ALPHA: begin
				inv2 = pacomp_pkg::ONE_Q16 - alf_s2;
				for (int ch = 0; ch < 3; ch++) begin
					src2[ch] = prod2[ch][32:16];
				end
			end
			pacomp_pkg::MODE_MUL_RED: begin
				inv2 = lin_s2[0];
				src2 = '0;
			end
			pacomp_pkg::MODE_PREMUL: begin
				inv2 = pacomp_pkg::ONE_Q16 - alf_s2;
				src2 = lin_s2;
			end
			default: begin
				inv2 = pacomp_pkg::ONE_Q16;
				src2 = lin_s2;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
		fresh_s3 <= (op_s2 == pacomp_pkg::OP_FRESH) || !inr_s2;
		src_s3 <= src2;
		inv_s3 <= inv2;
	end

	// stage 3: destination with forwarding from the two newest writes, then multiply
	always_comb begin
		priority if (fresh_s3) begin
			dstw = WORD_W'(pacomp_pkg::ONE_Q16);
		end else if (wr_s4 && idx_s4 == idx_s3) begin
			dstw = wdata;
		end else if (wr_s5 && idx_s5 == idx_s3) begin
			dstw = wdat_s5;
		end else begin
			dstw = rdata;
		end
		for (int ch = 0; ch < 3; ch++) begin
			dst3[ch] = dstw[17 + CB * ch +: CB];
			prod3[ch] = (CB + 17)'(dst3[ch]) * (CB + 17)'(inv_s3);
		end
		t3 = dstw[16:0];
		tprod3 = 34'(t3) * 34'(inv_s3);
	end

	always_ff @(posedge clk) begin
		idx_s4 <= idx_s3;
		for (int ch = 0; ch < 3; ch++) begin
			mul_s4[ch] <= prod3[ch][CB+16:16];
		end
		tn_s4 <= tprod3[32:16];
		src_s4 <= src_s3;
		rcol_s4 <= dst3;
		rt_s4 <= t3;
	end

	// stage 4: add source, saturate, write back
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum4[ch] = (CB + 2)'(mul_s4[ch]) + (CB + 2)'(src_s4[ch]);
			col4[ch] = (sum4[ch][CB+1:CB] != 2'b00) ? '1 : sum4[ch][CB-1:0];
		end
	end

	assign wdata = {col4[2], col4[1], col4[0], tn_s4};
	assign we = wr_s4;
	assign waddr = ADDR_W'(idx_s4);

	always_ff @(posedge clk) begin
		idx_s5 <= idx_s4;
		wdat_s5 <= wdata;
	end

	pacomp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// readout: two search bits per stage, coverage from transmittance
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			n4[ch] = srch(srch(8'h00, rcol_s4[ch], 8'h80), rcol_s4[ch], 8'h40);
			n5[ch] = srch(srch(rn_s5[ch], rcol_s5[ch], 8'h20), rcol_s5[ch], 8'h10);
			n6[ch] = srch(srch(rn_s6[ch], rcol_s6[ch], 8'h08), rcol_s6[ch], 8'h04);
			n7[ch] = srch(srch(rn_s7[ch], rcol_s7[ch], 8'h02), rcol_s7[ch], 8'h01);
		end
		tc4 = (rt_s4 > pacomp_pkg::ONE_Q16) ? pacomp_pkg::ONE_Q16 : rt_s4;
		cov4 = pacomp_pkg::ONE_Q16 - tc4;
		am4 = 25'(cov4) * 25'd255;
	end

	always_ff @(posedge clk) begin
		rcol_s5 <= rcol_s4;
		rn_s5 <= n4;
		ra_s5 <= am4[23:16];
		rcol_s6 <= rcol_s5;
		rn_s6 <= n5;
		ra_s6 <= ra_s5;
		rcol_s7 <= rcol_s6;
		rn_s7 <= n6;
		ra_s7 <= ra_s6;
	end

	// result queue entries
	always_ff @(posedge clk) begin
		if (rdo_s7) begin
			fifo_q[wptr_q] <= '{red_out: n7[0], green_out: n7[1], blue_out: n7[2],
				alpha_out: ra_s7};
		end
	end

	// result queue pointers, depth is a power of two so they wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (rdo_s7) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (out_acc) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (rdo_s7 && !out_acc) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (out_acc && !rdo_s7) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	assign out_valid = (ocnt_q != '0);
	assign out_data = fifo_q[rptr_q];

endmodule

### rtl/pacomp_ram.sv
// generic single-write, single-read ram with registered read data
module pacomp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// a read at the address being written returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/pacomp_checker.sv
// port-level checker for the layer compositor and its bind to the top level
module pacomp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input pacomp_pkg::in_item_t  in_data,
	input logic                  out_valid,
	input logic                  out_stall,
	input pacomp_pkg::out_item_t out_data
);

	localparam int OCNT_W = $clog2(pacomp_pkg::OUT_DEPTH + 1) + 1;

	logic rd_acc;
	logic out_acc;
	logic [OCNT_W-1:0] pend_q;

	assign rd_acc = in_valid && !in_stall && in_data.operation == pacomp_pkg::OP_READ;
	assign out_acc = out_valid && !out_stall;

	// readouts taken and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (rd_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !rd_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// every result answers an earlier readout
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result without a pending readout");

	// input back-pressure comes only from a full set of outstanding readouts
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (pend_q == OCNT_W'(pacomp_pkg::OUT_DEPTH)))
		else $error("input stall does not match outstanding readouts");

	// outstanding readouts never exceed the queue
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= OCNT_W'(pacomp_pkg::OUT_DEPTH))
		else $error("too many readouts outstanding");

endmodule

bind premul_alpha_layer_compositor_top pacomp_checker u_pacomp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);
